[hw/rtl/b64d_pkg.sv]
// Shared types, character codes and helper functions for the base64 decoder.
// No dependencies; every other file of the decoder uses this package.
package b64d_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);

    localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UZ    = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
    localparam logic [7:0] CH_D0    = 8'h30;  // '0'
    localparam logic [7:0] CH_D9    = 8'h39;  // '9'

    localparam logic [5:0] SX_PLUS  = 6'd62;
    localparam logic [5:0] SX_SLASH = 6'd63;
    localparam logic [7:0] OFS_LOW  = 8'd26;
    localparam logic [7:0] OFS_DIG  = 8'd52;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // One queued record: a decoded group (one to three bytes) or a status.
    typedef struct packed {
        t_kind           kind;
        logic [1:0]      last_idx;   // number of results minus one
        logic [2:0][7:0] bytes;      // bytes[0] comes out first
        logic [31:0]     count;
    } t_rec;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Map a character to its sextet; bit 6 flags a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA;
            return {1'b0, d[5:0]};
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + OFS_LOW;
            return {1'b0, d[5:0]};
        end else if (c >= CH_D0 && c <= CH_D9) begin
            d = c - CH_D0 + OFS_DIG;
            return {1'b0, d[5:0]};
        end else if (c == CH_PLUS) begin
            return {1'b0, SX_PLUS};
        end else if (c == CH_SLASH) begin
            return {1'b0, SX_SLASH};
        end
        return 7'h40;
    endfunction

    // Fit the running total into the 32-bit result field.
    function automatic logic [31:0] count_to_field(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+31:0] ext;
        ext = {32'd0, v};
        return ext[31:0];
    endfunction

endpackage

[hw/rtl/base64_stream_decoder.sv]
// Top level of the streaming base64 decoder: front end, record queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Streaming base64 (standard alphabet) decoder with queue-style ports. One
// character, or an end marker, is taken per cycle whenever o_full is low;
// o_full rises only when the four-entry record queue fills. Space, tab, CR and
// LF are skipped. Every fourth alphabet or pad character gives one to three
// data results, one per cycle from the output register while each is popped;
// an error gives one kind 2 result and latches failure until the end marker,
// and the end marker gives a single kind 1 (with the saturating byte total) or
// kind 2 result and clears the front end's state. o_last marks the final
// result of each input item. Results pass through the record queue and the
// output register; as four characters give at most three bytes, one
// character per cycle, set by the group logic, holds while results are popped.
module base64_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_marker,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic [31:0] o_byte_count,
    output logic        o_last
);

    logic           f_wr;
    b64d_pkg::t_rec f_rec;
    logic           q_full;
    logic           q_valid;
    logic           q_rd;
    b64d_pkg::t_rec q_rec;

    assign o_full = q_full;

    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (i_push && !q_full),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .o_wr         (f_wr),
        .o_rec        (f_rec)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_rec   (f_rec),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_rec      (q_rec),
        .o_q_rd       (q_rd),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

endmodule

[hw/rtl/b64d_front.sv]
// Front end of the base64 decoder: classifies characters, collects groups,
// tracks padding, failure and the byte total, and writes records to the queue.
// Depends on b64d_pkg.
module b64d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_char_code,
    input  logic              i_end_marker,
    output logic              o_wr,
    output b64d_pkg::t_rec    o_rec
);

    localparam logic [b64d_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [2:0][5:0]                  r_held;
    logic [1:0]                       r_held_count;
    logic                             r_pad_seen;
    logic [1:0]                       r_pad_pos;
    logic                             r_pad_done;
    logic                             r_failed;
    logic [b64d_pkg::COUNT_WIDTH-1:0] r_total;

    logic [2:0][5:0]                  n_held;
    logic [1:0]                       n_held_count;
    logic                             n_pad_seen;
    logic [1:0]                       n_pad_pos;
    logic                             n_pad_done;
    logic                             n_failed;
    logic [b64d_pkg::COUNT_WIDTH-1:0] n_total;

    logic [6:0]                       sx;
    logic [5:0]                       s;
    logic                             fault;
    logic                             is_pad;
    logic [1:0]                       lidx;
    logic [b64d_pkg::COUNT_WIDTH-1:0] add_n;

    always_comb begin
        n_held       = r_held;
        n_held_count = r_held_count;
        n_pad_seen   = r_pad_seen;
        n_pad_pos    = r_pad_pos;
        n_pad_done   = r_pad_done;
        n_failed     = r_failed;
        n_total      = r_total;
        o_wr         = 1'b0;
        o_rec        = '0;
        o_rec.kind   = b64d_pkg::KIND_ERR;
        sx           = b64d_pkg::sextet_of(i_char_code);
        is_pad       = (i_char_code == b64d_pkg::CH_PAD);
        s            = is_pad ? 6'd0 : sx[5:0];
        fault        = is_pad ? (r_pad_done || r_held_count < 2'd2)
                              : (sx[6] || r_pad_done || r_pad_seen);
        // a first '=' in the fourth position closes the group with two bytes
        lidx         = r_pad_seen ? ((r_pad_pos == 2'd2) ? 2'd0 : 2'd1)
                                  : (is_pad ? 2'd1 : 2'd2);
        add_n        = {{(b64d_pkg::COUNT_WIDTH-2){1'b0}}, lidx} + 1'b1;

        if (i_take) begin
            if (i_end_marker) begin
                o_wr = 1'b1;
                if (r_failed || r_held_count != 2'd0) begin
                    o_rec.kind = b64d_pkg::KIND_ERR;
                end else begin
                    o_rec.kind  = b64d_pkg::KIND_OK;
                    o_rec.count = b64d_pkg::count_to_field(r_total);
                end
                n_held_count = 2'd0;
                n_pad_seen   = 1'b0;
                n_pad_pos    = 2'd0;
                n_pad_done   = 1'b0;
                n_failed     = 1'b0;
                n_total      = '0;
            end else if (!b64d_pkg::is_blank(i_char_code) && !r_failed) begin
                if (fault) begin
                    o_wr       = 1'b1;
                    o_rec.kind = b64d_pkg::KIND_ERR;
                    n_failed   = 1'b1;
                end else begin
                    // remember where padding started; it sets the byte count
                    if (is_pad && !r_pad_seen) begin
                        n_pad_seen = 1'b1;
                        n_pad_pos  = r_held_count;
                    end
                    if (r_held_count != 2'd3) begin
                        n_held[r_held_count] = s;
                        n_held_count = r_held_count + 2'd1;
                    end else begin
                        o_wr           = 1'b1;
                        o_rec.kind     = b64d_pkg::KIND_DATA;
                        o_rec.last_idx = lidx;
                        o_rec.bytes[0] = {r_held[0], r_held[1][5:4]};
                        o_rec.bytes[1] = {r_held[1][3:0], r_held[2][5:2]};
                        o_rec.bytes[2] = {r_held[2][1:0], s};
                        // saturating add of one to three bytes
                        n_total = (r_total > CNT_MAX - add_n) ? CNT_MAX : r_total + add_n;
                        n_pad_done   = r_pad_seen || is_pad;
                        n_pad_seen   = 1'b0;
                        n_pad_pos    = 2'd0;
                        n_held_count = 2'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_pad_seen   <= 1'b0;
            r_pad_pos    <= 2'd0;
            r_pad_done   <= 1'b0;
            r_failed     <= 1'b0;
            r_total      <= '0;
        end else begin
            r_held_count <= n_held_count;
            r_pad_seen   <= n_pad_seen;
            r_pad_pos    <= n_pad_pos;
            r_pad_done   <= n_pad_done;
            r_failed     <= n_failed;
            r_total      <= n_total;
        end
    end

endmodule

[hw/rtl/b64d_queue.sv]
// Short record queue between the decoder front end and the result serializer.
// Depends on b64d_pkg.
module b64d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  b64d_pkg::t_rec    i_rec,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_valid,
    output b64d_pkg::t_rec    o_rec
);

    b64d_pkg::t_rec             r_mem [b64d_pkg::QDEPTH];
    logic [b64d_pkg::QAW-1:0]   r_wp;
    logic [b64d_pkg::QAW-1:0]   r_rp;
    logic [b64d_pkg::QAW:0]     r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == (b64d_pkg::QAW+1)'(b64d_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_rec;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == b64d_pkg::QAW'(b64d_pkg::QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == b64d_pkg::QAW'(b64d_pkg::QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/b64d_back.sv]
// Back end of the base64 decoder: splits queued records into result items
// and holds the oldest one in an output register until it is popped.
// Depends on b64d_pkg.
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  b64d_pkg::t_rec    i_q_rec,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic [1:0]        o_kind,
    output logic [31:0]       o_byte_count,
    output logic              o_last
);

    logic        r_valid;
    logic [1:0]  r_idx;
    logic [7:0]  r_byte;
    logic [1:0]  r_kind;
    logic [31:0] r_count;
    logic        r_last;

    logic        load;
    logic        at_last;
    logic [7:0]  sel_byte;

    assign load    = i_q_valid && (!r_valid || i_pop);
    assign at_last = (r_idx == i_q_rec.last_idx);
    assign o_q_rd  = load && at_last;

    always_comb begin
        unique case (r_idx)
            2'd0:    sel_byte = i_q_rec.bytes[0];
            2'd1:    sel_byte = i_q_rec.bytes[1];
            default: sel_byte = i_q_rec.bytes[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= sel_byte;
            r_kind  <= i_q_rec.kind;
            r_count <= i_q_rec.count;
            r_last  <= at_last;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                // advance through the record, rewind once its last byte is out
                r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_valid;
    assign o_out_byte   = r_byte;
    assign o_kind       = r_kind;
    assign o_byte_count = r_count;
    assign o_last       = r_last;

endmodule
